>>> rtl/srw_pkg.sv
package srw_pkg;

  // field widths
  localparam int SRC_W  = 4;
  localparam int SEQ_W  = 16;
  localparam int TIME_W = 32;
  localparam int ORD_W  = 32;

  // window geometry and counter step
  localparam int WINDOW_BITS = 64;
  localparam int AGE_W       = $clog2(WINDOW_BITS);
  localparam logic [ORD_W-1:0]  REANCHOR_STEP = 32'h0001_0000;
  localparam logic [TIME_W-1:0] TTL_RESET     = 32'd60000;

  // default source count
  localparam int NUM_SOURCES_DEF = 16;

  // one source's tracker entry as held in the state memory
  typedef struct packed {
    logic [SEQ_W-1:0]       high_sequence;
    logic [TIME_W-1:0]      high_time;
    logic [WINDOW_BITS-1:0] seen_map;
    logic [ORD_W-1:0]       order_counter;
  } entry_t;

  // verdict for one request
  typedef struct packed {
    logic             accepted;
    logic             reanchored;
    logic [ORD_W-1:0] extended_order;
  } result_t;

endpackage

>>> rtl/srw_evt_if.sv
interface srw_evt_if;
  import srw_pkg::*;

  logic              valid;
  logic              ready;
  logic [SRC_W-1:0]  source_index;
  logic [SEQ_W-1:0]  sequence_req;
  logic [TIME_W-1:0] now_ms;
  logic              restart;

  modport source (output valid, source_index, sequence_req, now_ms, restart, input ready);
  modport sink   (input valid, source_index, sequence_req, now_ms, restart, output ready);
endinterface

>>> rtl/srw_res_if.sv
interface srw_res_if;
  import srw_pkg::*;

  logic             valid;
  logic             ready;
  logic             accepted;
  logic             reanchored;
  logic [ORD_W-1:0] extended_order;

  modport source (output valid, accepted, reanchored, extended_order, input ready);
  modport sink   (input valid, accepted, reanchored, extended_order, output ready);
endinterface

>>> rtl/srw_mem.sv
module srw_mem #(
  parameter int DEPTH = srw_pkg::NUM_SOURCES_DEF,
  parameter int AW    = 4
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  srw_pkg::entry_t      wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output srw_pkg::entry_t      rdata
);
  import srw_pkg::*;

  entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

>>> rtl/srw_update.sv
module srw_update (
  input  logic                      in_range,
  input  logic                      ent_valid,
  input  srw_pkg::entry_t           ent,
  input  logic [srw_pkg::SEQ_W-1:0]  seq,
  input  logic [srw_pkg::TIME_W-1:0] now,
  input  logic                      restart,
  input  logic [srw_pkg::TIME_W-1:0] ttl,
  output srw_pkg::entry_t           ent_next,
  output logic                      wr_en,
  output srw_pkg::result_t          res
);
  import srw_pkg::*;

  logic [SEQ_W-1:0]  lead;
  logic [SEQ_W-1:0]  age;
  logic [TIME_W-1:0] quiet;
  logic [ORD_W-1:0]  order;
  logic [ORD_W-1:0]  addend;
  logic [ORD_W-1:0]  sum;
  logic              anchor;
  logic              newer;
  logic              in_window;
  logic              ok;

  // classify the request against the stored window
  always_comb begin
    lead      = seq - ent.high_sequence;
    age       = ent.high_sequence - seq;
    quiet     = now - ent.high_time;
    order     = ent_valid ? ent.order_counter : '0;
    anchor    = in_range && (!ent_valid || restart || (quiet >= ttl));
    newer     = in_range && !anchor && (lead != '0) && !lead[SEQ_W-1];
    in_window = in_range && !anchor && !newer &&
                (age < SEQ_W'(WINDOW_BITS)) && !ent.seen_map[age[AGE_W-1:0]];
    ok        = anchor || newer || in_window;
  end

  // one adder serves the counter advance and the order of an older number
  always_comb begin
    priority if (anchor) begin
      addend = REANCHOR_STEP;
    end else if (newer) begin
      addend = ORD_W'(lead);
    end else begin
      addend = ORD_W'(0) - ORD_W'(age);
    end
    sum = order + addend;
  end

  // next entry and verdict
  always_comb begin
    ent_next = ent;
    ent_next.order_counter = order;
    priority if (anchor) begin
      ent_next.high_sequence = seq;
      ent_next.high_time     = now;
      ent_next.seen_map      = WINDOW_BITS'(1);
      ent_next.order_counter = sum;
    end else if (newer) begin
      ent_next.high_sequence = seq;
      ent_next.high_time     = now;
      ent_next.order_counter = sum;
      if (lead >= SEQ_W'(WINDOW_BITS)) begin
        ent_next.seen_map = WINDOW_BITS'(1);
      end else begin
        ent_next.seen_map = (ent.seen_map << lead[AGE_W-1:0]) | WINDOW_BITS'(1);
      end
    end else if (in_window) begin
      ent_next.seen_map = ent.seen_map | (WINDOW_BITS'(1) << age[AGE_W-1:0]);
    end else begin
      ent_next = ent;
    end
    wr_en              = ok;
    res.accepted       = ok;
    res.reanchored     = anchor;
    res.extended_order = ok ? sum : '0;
  end
endmodule

>>> rtl/sequence_replay_window.sv
// Channel  | Dir | Payload                                         | Handshake
// evt      | in  | source_index, sequence_req, now_ms, restart     | valid/ready
// res      | out | accepted, reanchored, extended_order            | valid/ready
// ttl      | cfg | ttl_wdata (32b)                                 | ttl_we
//
// One request per cycle sustained while results are taken. The read stage
// reads the source entry from the state memory, the update stage updates it
// and writes it back; a back-to-back request to the same source takes the
// value being written through a one-entry forward register.
// Reset (rst, synchronous) clears the per-source valid bits and the pipeline.
// A stalled result holds the update stage; requests keep flowing while the
// result register is free or being taken.
module sequence_replay_window #(
  parameter int NUM_SOURCES = srw_pkg::NUM_SOURCES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       ttl_we,
  input  logic [srw_pkg::TIME_W-1:0] ttl_wdata,
  srw_evt_if.sink                    evt,
  srw_res_if.source                  res
);
  import srw_pkg::*;

  localparam int AW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

  logic [TIME_W-1:0] ttl_ms;

  logic              evt_fire;
  logic              s1_adv;
  logic              s1_valid;
  logic [AW-1:0]     s1_addr;
  logic              s1_in_range;
  logic [SEQ_W-1:0]  s1_seq;
  logic [TIME_W-1:0] s1_now;
  logic              s1_restart;
  logic              fwd_sel;
  entry_t            fwd_data;
  entry_t            rd_data;
  entry_t            ent_cur;
  entry_t            ent_next;
  logic              upd_wr;
  logic              wr_en;
  result_t           upd_res;
  logic [NUM_SOURCES-1:0] vbits;
  logic              ent_valid;
  logic [AW-1:0]     evt_addr;
  logic              evt_in_range;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      ttl_ms <= TTL_RESET;
    end else if (ttl_we) begin
      ttl_ms <= ttl_wdata;
    end
  end

  // handshake
  assign s1_adv       = !res.valid || res.ready;
  assign evt.ready    = !s1_valid || s1_adv;
  assign evt_fire     = evt.valid && evt.ready;
  assign evt_addr     = AW'(evt.source_index);
  assign evt_in_range = (32'(evt.source_index) < NUM_SOURCES);
  assign wr_en        = s1_valid && s1_adv && upd_wr;

  // state memory
  srw_mem #(.DEPTH(NUM_SOURCES), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_addr),
    .wdata (ent_next),
    .re    (evt_fire),
    .raddr (evt_addr),
    .rdata (rd_data)
  );

  // update stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_sel  <= 1'b0;
    end else if (evt.ready) begin
      s1_valid <= evt.valid;
      fwd_sel  <= wr_en && (s1_addr == evt_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (evt_fire) begin
      s1_addr     <= evt_addr;
      s1_in_range <= evt_in_range;
      s1_seq      <= evt.sequence_req;
      s1_now      <= evt.now_ms;
      s1_restart  <= evt.restart;
    end
  end

  // forward the entry written on the same edge as the read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_data <= ent_next;
    end
  end

  // per-source valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vbits <= '0;
    end else if (wr_en) begin
      vbits[s1_addr] <= 1'b1;
    end
  end

  assign ent_cur   = fwd_sel ? fwd_data : rd_data;
  assign ent_valid = s1_in_range && vbits[s1_addr];

  srw_update u_update (
    .in_range  (s1_in_range),
    .ent_valid (ent_valid),
    .ent       (ent_cur),
    .seq       (s1_seq),
    .now       (s1_now),
    .restart   (s1_restart),
    .ttl       (ttl_ms),
    .ent_next  (ent_next),
    .wr_en     (upd_wr),
    .res       (upd_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (s1_adv) begin
      res.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      res.accepted       <= upd_res.accepted;
      res.reanchored     <= upd_res.reanchored;
      res.extended_order <= upd_res.extended_order;
    end
  end

  // checks
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.accepted |-> (res.extended_order == '0) && !res.reanchored)
    else $error("rejected result carries order or re-anchor flag");

  a_wr_in_stage: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> s1_valid && s1_in_range)
    else $error("state write without a live in-range request");

  a_valid_after_wr: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> vbits[$past(s1_addr)])
    else $error("valid bit not set after entry write");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_seq) && $stable(s1_addr))
    else $error("update stage lost request while stalled");
endmodule

>>> dv/sequence_replay_window_tb.sv
`timescale 1ns / 1ps

module sequence_replay_window_tb;
  import srw_pkg::*;

  localparam int SOURCES     = NUM_SOURCES_DEF;
  localparam int STALL_LIMIT = 4000;

  logic clk;
  logic rst;
  logic ttl_we;
  logic [TIME_W-1:0] ttl_wdata;

  srw_evt_if evt_ch ();
  srw_res_if res_ch ();

  sequence_replay_window #(
    .NUM_SOURCES(SOURCES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .ttl_we   (ttl_we),
    .ttl_wdata(ttl_wdata),
    .evt      (evt_ch),
    .res      (res_ch)
  );

  // tracker shadow, one entry per source
  logic                   trk_valid [SOURCES];
  logic [SEQ_W-1:0]       trk_high  [SOURCES];
  logic [TIME_W-1:0]      trk_time  [SOURCES];
  logic [WINDOW_BITS-1:0] trk_map   [SOURCES];
  logic [ORD_W-1:0]       trk_order [SOURCES];
  logic [TIME_W-1:0]      ttl_shadow;

  // verdicts owed by the block, oldest first
  result_t pending_verdicts[$];

  // stimulus helpers
  logic [SEQ_W-1:0]  seq_cursor [SOURCES];
  logic [TIME_W-1:0] wall_ms;
  bit                tx_idle_on;
  bit                rx_idle_on;
  int unsigned       mismatch_count;
  int unsigned       stall_cycles;

  always #2 clk = ~clk;

  // verdict for one request; updates the shadow like the block does
  function automatic result_t predict_verdict(input logic [SRC_W-1:0] src,
                                              input logic [SEQ_W-1:0] seq,
                                              input logic [TIME_W-1:0] now,
                                              input logic restart_f);
    result_t           r;
    logic [TIME_W-1:0] quiet;
    logic [SEQ_W-1:0]  lead;
    logic [SEQ_W-1:0]  age;
    r = '0;
    quiet = now - trk_time[src];
    lead = seq - trk_high[src];
    age = trk_high[src] - seq;
    if (!trk_valid[src] || restart_f || quiet >= ttl_shadow) begin
      // re-anchor on this number
      trk_order[src] = trk_order[src] + REANCHOR_STEP;
      trk_valid[src] = 1'b1;
      trk_high[src]  = seq;
      trk_map[src]   = WINDOW_BITS'(1);
      trk_time[src]  = now;
      r.accepted     = 1'b1;
      r.reanchored   = 1'b1;
    end else if (lead != '0 && !lead[SEQ_W-1]) begin
      // newer number: slide the window forward
      trk_order[src] = trk_order[src] + ORD_W'(lead);
      if (lead >= WINDOW_BITS) trk_map[src] = WINDOW_BITS'(1);
      else trk_map[src] = (trk_map[src] << lead) | WINDOW_BITS'(1);
      trk_high[src] = seq;
      trk_time[src] = now;
      r.accepted    = 1'b1;
    end else if (age < WINDOW_BITS && !trk_map[src][age[AGE_W-1:0]]) begin
      // late number inside the window, first sighting
      trk_map[src][age[AGE_W-1:0]] = 1'b1;
      r.accepted = 1'b1;
    end
    if (r.accepted) begin
      age = trk_high[src] - seq;
      r.extended_order = trk_order[src] - ORD_W'(age);
    end
    return r;
  endfunction

  // one request; leaves valid high on return, just after a falling edge
  task automatic post_event(input logic [SRC_W-1:0] src, input logic [SEQ_W-1:0] seq,
                            input logic [TIME_W-1:0] now, input logic restart_f);
    while (tx_idle_on && $urandom_range(99) < 9) begin
      evt_ch.valid <= 1'b0;
      @(negedge clk);
    end
    evt_ch.valid        <= 1'b1;
    evt_ch.source_index <= src;
    evt_ch.sequence_req <= seq;
    evt_ch.now_ms       <= now;
    evt_ch.restart      <= restart_f;
    @(posedge clk);
    while (!evt_ch.ready) @(posedge clk);
    pending_verdicts.push_back(predict_verdict(src, seq, now, restart_f));
    @(negedge clk);
  endtask

  // stop sending and wait until every verdict is back
  task automatic settle_pipeline();
    evt_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_ttl(input logic [TIME_W-1:0] value);
    settle_pipeline();
    ttl_we     <= 1'b1;
    ttl_wdata  <= value;
    ttl_shadow = value;
    @(negedge clk);
    ttl_we <= 1'b0;
  endtask

  // untouched sources re-anchor; extremes of every field
  task automatic test_first_contact();
    post_event(4'd0, 16'h0000, 32'h0000_0000, 1'b0);
    post_event(4'd15, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
  endtask

  // shifts, duplicates, window edge and large jump
  task automatic test_window_slide();
    post_event(4'd1, 16'd100, 32'd1000, 1'b0);
    post_event(4'd1, 16'd101, 32'd1000, 1'b0);
    post_event(4'd1, 16'd101, 32'd1000, 1'b0);  // same as high
    post_event(4'd1, 16'd99, 32'd1000, 1'b0);
    post_event(4'd1, 16'd99, 32'd1000, 1'b0);
    post_event(4'd1, 16'd164, 32'd1000, 1'b0);  // shift by 63
    post_event(4'd1, 16'd101, 32'd1000, 1'b0);  // oldest slot, already seen
    post_event(4'd1, 16'd100, 32'd1000, 1'b0);  // just out of the window
    post_event(4'd1, 16'd228, 32'd1000, 1'b0);  // jump of 64 clears the map
    post_event(4'd1, 16'd165, 32'd1000, 1'b0);
  endtask

  // sequence wrap and the half-range ambiguity
  task automatic test_sequence_wrap();
    post_event(4'd2, 16'hFFF0, 32'd2000, 1'b0);
    post_event(4'd2, 16'h0005, 32'd2000, 1'b0);
    post_event(4'd2, 16'hFFF5, 32'd2000, 1'b0);
    post_event(4'd2, 16'h8005, 32'd2000, 1'b0);
  endtask

  // quiet time just under and at the ttl, across a time wrap
  task automatic test_ttl_boundary();
    post_event(4'd3, 16'd7, 32'hFFFF_FF00, 1'b0);
    post_event(4'd3, 16'd8, 32'hFFFF_FF00 + 32'd59999, 1'b0);
    post_event(4'd3, 16'd9, 32'hFFFF_FF00 + 32'd119999, 1'b0);
  endtask

  task automatic test_restart();
    post_event(4'd4, 16'h1234, 32'd5, 1'b0);
    post_event(4'd4, 16'h1234, 32'd5, 1'b1);
    post_event(4'd4, 16'h1233, 32'd5, 1'b0);
  endtask

  task automatic test_short_ttl();
    set_ttl(32'd1);
    post_event(4'd5, 16'd10, 32'd50, 1'b0);
    post_event(4'd5, 16'd11, 32'd50, 1'b0);
    post_event(4'd5, 16'd12, 32'd51, 1'b0);
  endtask

  task automatic test_longest_ttl();
    set_ttl(32'hFFFF_FFFF);
    post_event(4'd6, 16'd1, 32'd100, 1'b0);
    post_event(4'd6, 16'd2, 32'd98, 1'b0);   // one short of the ttl
    post_event(4'd6, 16'd3, 32'd97, 1'b0);   // exactly the ttl
  endtask

  // mostly plausible per-source streams, some noise
  task automatic test_random_traffic(input int unsigned n_events,
                                     input int unsigned calm_from,
                                     input int unsigned calm_len);
    logic [SRC_W-1:0] src;
    logic [SEQ_W-1:0] seq;
    logic             restart_f;
    int unsigned      pick;
    src = SRC_W'($urandom);
    wall_ms = $urandom;
    for (int unsigned i = 0; i < n_events; i++) begin
      tx_idle_on = !(i >= calm_from && i < calm_from + calm_len);
      rx_idle_on = tx_idle_on;
      // stay on one source often, to hit back-to-back updates
      if ($urandom_range(99) >= 60) src = SRC_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 45) wall_ms = wall_ms;
      else if (pick < 90) wall_ms = wall_ms + $urandom_range(1, 50);
      else if (pick < 97) wall_ms = wall_ms + ttl_shadow - $urandom_range(0, 2);
      else wall_ms = $urandom;
      pick = $urandom_range(99);
      if (pick < 55) begin
        seq = seq_cursor[src] + SEQ_W'($urandom_range(1, 8));
        seq_cursor[src] = seq;
      end else if (pick < 78) begin
        seq = seq_cursor[src] - SEQ_W'($urandom_range(0, 70));
      end else if (pick < 86) begin
        seq = seq_cursor[src];
      end else if (pick < 92) begin
        seq = seq_cursor[src] + SEQ_W'($urandom_range(56, 72));
        seq_cursor[src] = seq;
      end else if (pick < 96) begin
        seq = seq_cursor[src] + 16'h7FFF + SEQ_W'($urandom_range(0, 2));
      end else begin
        seq = SEQ_W'($urandom);
        seq_cursor[src] = seq;
      end
      restart_f = ($urandom_range(99) < 3);
      post_event(src, seq, wall_ms, restart_f);
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // result side back-pressure
  always @(negedge clk) begin
    res_ch.ready <= !rx_idle_on || ($urandom_range(99) >= 9);
  end

  // compare each verdict with the oldest one owed
  always @(posedge clk) begin
    result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected verdict accepted=%0b reanchored=%0b order=%08h", $time,
                 res_ch.accepted, res_ch.reanchored, res_ch.extended_order);
        mismatch_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (res_ch.accepted !== want.accepted || res_ch.reanchored !== want.reanchored ||
            res_ch.extended_order !== want.extended_order) begin
          $display("%0t: expected accepted=%0b reanchored=%0b order=%08h, got %0b %0b %08h",
                   $time, want.accepted, want.reanchored, want.extended_order,
                   res_ch.accepted, res_ch.reanchored, res_ch.extended_order);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog: no progress on either channel for too long
  always @(posedge clk) begin
    if (rst || (evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    ttl_we = 1'b0;
    ttl_wdata = '0;
    evt_ch.valid = 1'b0;
    evt_ch.source_index = '0;
    evt_ch.sequence_req = '0;
    evt_ch.now_ms = '0;
    evt_ch.restart = 1'b0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    ttl_shadow = TTL_RESET;
    for (int i = 0; i < SOURCES; i++) begin
      trk_valid[i]  = 1'b0;
      trk_high[i]   = '0;
      trk_time[i]   = '0;
      trk_map[i]    = '0;
      trk_order[i]  = '0;
      seq_cursor[i] = SEQ_W'($urandom);
    end
    wall_ms = '0;

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_first_contact();
    test_window_slide();
    test_sequence_wrap();
    test_ttl_boundary();
    test_restart();
    test_random_traffic(650, 200, 300);
    test_short_ttl();
    test_random_traffic(250, 0, 0);
    set_ttl($urandom_range(2, 200000));
    test_random_traffic(450, 0, 0);
    test_longest_ttl();
    test_random_traffic(450, 100, 150);

    settle_pipeline();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
